// ===== rtl/ebds_pkg.sv =====
// Shared constants, types and helper functions for the encoder and button duty stepper.
`timescale 1ns / 1ps

package ebds_pkg;

	localparam int STEP_SIZE   = 50;
	localparam int MAX_STEP    = 1200;
	localparam int COUNT_LIMIT = 255;

	localparam int STEP_W  = 11;
	localparam int DUTY_W  = 16;
	localparam int COUNT_W = 8;
	localparam int HOLD_W  = 16;
	localparam int EDGE_W  = 8;
	localparam int EVENT_W = 2;

	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = 16;

	localparam logic [HOLD_W-1:0] HOLD_TICKS_RESET = HOLD_W'(500);
	localparam logic [EDGE_W-1:0] EDGE_MIN_RESET   = EDGE_W'(5);
	localparam logic [STEP_W-1:0] STEP_RESET       = STEP_W'(0);
	// The duty resets to 10000, which is this step times STEP_SIZE.
	localparam logic [STEP_W-1:0] DUTY_STEP_RESET  = STEP_W'(10000 / STEP_SIZE);

	// One tenth of full scale, and a reciprocal for flooring a step to it.
	localparam int TENTH        = MAX_STEP / 10;
	localparam int RECIP_SHIFT  = 20;
	localparam int RECIP        = ((1 << RECIP_SHIFT) + TENTH - 1) / TENTH;
	localparam int RECIP_W      = $clog2(RECIP + 1);
	localparam int PROD_W       = STEP_W + RECIP_W;
	localparam int SIZE_W       = $clog2(STEP_SIZE + 1);
	localparam int DUTY_PROD_W  = STEP_W + SIZE_W;

	localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(COUNT_LIMIT);

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_HOLD_TICKS = 1'b0,
		CFG_EDGE_MIN   = 1'b1
	} cfg_index_t;

	typedef enum logic [EVENT_W-1:0] {
		EV_NONE      = 2'd0,
		EV_BUTTON    = 2'd1,
		EV_STEP_UP   = 2'd2,
		EV_STEP_DOWN = 2'd3
	} event_kind_t;

	typedef struct packed {
		logic [DUTY_W-1:0] duty_value;
		logic [STEP_W-1:0] step_value;
		event_kind_t       event_kind;
	} result_t;

	// Floors the step to a multiple of one tenth, adds one tenth, wraps past the top.
	function automatic logic [STEP_W-1:0] jump_step(input logic [STEP_W-1:0] step);
		logic [PROD_W-1:0] prod;
		logic [STEP_W-1:0] quot;
		logic [STEP_W:0]   nxt;
		prod = PROD_W'(step) * PROD_W'(RECIP);
		quot = STEP_W'(prod >> RECIP_SHIFT);
		nxt = (STEP_W + 1)'(quot) * (STEP_W + 1)'(TENTH) + (STEP_W + 1)'(TENTH);
		if (nxt > (STEP_W + 1)'(MAX_STEP)) begin
			return '0;
		end
		return STEP_W'(nxt);
	endfunction

	// Duty for a step, saturated to the duty width.
	function automatic logic [DUTY_W-1:0] duty_of(input logic [STEP_W-1:0] step);
		logic [DUTY_PROD_W-1:0] prod;
		prod = DUTY_PROD_W'(step) * DUTY_PROD_W'(STEP_SIZE);
		if (prod > DUTY_PROD_W'({DUTY_W{1'b1}})) begin
			return {DUTY_W{1'b1}};
		end
		return DUTY_W'(prod);
	endfunction

endpackage

// ===== rtl/encoder_button_duty_stepper.sv =====
// Top level of the encoder and button duty stepper with its output skid stage.
`timescale 1ns / 1ps

// Each input transfer is one sample tick of the active-low button and encoder pins and
// yields exactly one result transfer with the duty, the step and the event of that tick.
// The block takes one tick per clock cycle while s_tready is high; results are registered and
// a two-entry output stage keeps the input open while one result waits. The step state
// is updated in the same cycle a tick is taken, so ticks follow back to back. The two
// configuration registers are written through the cfg channel, which is always ready.

module encoder_button_duty_stepper
	import ebds_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,

	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [7:0]             s_tdata,   // button_level, chan_a_level, chan_b_level, zeros

	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [31:0]            m_tdata,   // duty_value[15:0], step_value[26:16], zeros
	output logic [EVENT_W-1:0]     m_tuser,   // event_kind

	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	logic [HOLD_W-1:0]  hold_ticks_q;
	logic [EDGE_W-1:0]  edge_min_q;

	logic [HOLD_W-1:0]  hold_count_q, hold_n;
	logic               press_latched_q, latched_n;
	logic [COUNT_W-1:0] a_count_q, a_n;
	logic [COUNT_W-1:0] b_count_q, b_n;
	logic [STEP_W-1:0]  step_q, step_n;
	logic [STEP_W-1:0]  duty_step_q, duty_step_n;
	event_kind_t        event_n;

	logic               btn_level, a_idle, b_idle;
	logic               in_xfer;
	logic [STEP_W-1:0]  detent_step;
	result_t            result_n;

	result_t            out_q, skid_q;
	logic               out_valid_q, skid_valid_q;

	assign btn_level = s_tdata[0];
	assign a_idle    = s_tdata[1];
	assign b_idle    = s_tdata[2];

	assign s_tready  = !skid_valid_q;
	assign in_xfer   = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	always_comb begin
		hold_n      = hold_count_q;
		latched_n   = press_latched_q;
		a_n         = a_count_q;
		b_n         = b_count_q;
		step_n      = step_q;
		duty_step_n = duty_step_q;
		event_n     = EV_NONE;
		detent_step = duty_step_q;

		if (!btn_level && a_count_q == '0 && b_count_q == '0) begin
			if (!press_latched_q) begin
				hold_n = hold_count_q + HOLD_W'(1);
				if (hold_n >= hold_ticks_q) begin
					latched_n   = 1'b1;
					step_n      = jump_step(step_q);
					duty_step_n = step_n;
					event_n     = EV_BUTTON;
				end
			end
		end else begin
			hold_n    = '0;
			latched_n = 1'b0;
		end

		// Channel B sees the updated A count when testing saturation.
		if (!a_idle && a_count_q < COUNT_MAX && b_count_q < COUNT_MAX && hold_n == '0) begin
			a_n = a_count_q + COUNT_W'(1);
		end
		if (!b_idle && a_n < COUNT_MAX && b_count_q < COUNT_MAX && hold_n == '0) begin
			b_n = b_count_q + COUNT_W'(1);
		end

		if (a_idle && b_idle) begin
			if (a_n > COUNT_W'(edge_min_q) && b_n > COUNT_W'(edge_min_q)) begin
				detent_step = duty_step_n;
				if (a_n > b_n) begin
					if (detent_step < STEP_W'(MAX_STEP)) begin
						detent_step = detent_step + STEP_W'(1);
					end
					event_n = EV_STEP_UP;
				end else begin
					if (detent_step > '0) begin
						detent_step = detent_step - STEP_W'(1);
					end
					event_n = EV_STEP_DOWN;
				end
				step_n      = detent_step;
				duty_step_n = detent_step;
			end
			a_n = '0;
			b_n = '0;
		end

		result_n.duty_value = duty_of(duty_step_n);
		result_n.step_value = step_n;
		result_n.event_kind = event_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_ticks_q <= HOLD_TICKS_RESET;
			edge_min_q   <= EDGE_MIN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index_t'(cfg_index))
				CFG_HOLD_TICKS: hold_ticks_q <= cfg_data[HOLD_W-1:0];
				CFG_EDGE_MIN:   edge_min_q   <= cfg_data[EDGE_W-1:0];
				default:        ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_count_q    <= '0;
			press_latched_q <= 1'b0;
			a_count_q       <= '0;
			b_count_q       <= '0;
			step_q          <= STEP_RESET;
			duty_step_q     <= DUTY_STEP_RESET;
		end else if (in_xfer) begin
			hold_count_q    <= hold_n;
			press_latched_q <= latched_n;
			a_count_q       <= a_n;
			b_count_q       <= b_n;
			step_q          <= step_n;
			duty_step_q     <= duty_step_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || m_tready) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= in_xfer;
			end
		end else if (in_xfer) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || m_tready) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (in_xfer) begin
				out_q <= result_n;
			end
		end else if (in_xfer) begin
			skid_q <= result_n;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'd0, out_q.step_value, out_q.duty_value};
	assign m_tuser  = out_q.event_kind;

endmodule

// ===== bench/ebds_checker.sv =====
// Checker that predicts every result of the duty stepper and compares it with the output stream.
`timescale 1ns / 1ps

module ebds_checker
	import ebds_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	input  logic                   s_tready,
	input  logic [7:0]             s_tdata,
	input  logic                   m_tvalid,
	input  logic                   m_tready,
	input  logic [31:0]            m_tdata,
	input  logic [EVENT_W-1:0]     m_tuser,
	input  logic                   cfg_valid,
	input  logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	output int                     mismatches,
	output int                     outstanding
);

	logic [HOLD_W-1:0]  hold_ticks = HOLD_TICKS_RESET;
	logic [EDGE_W-1:0]  edge_min   = EDGE_MIN_RESET;
	logic [HOLD_W-1:0]  hold_cnt   = '0;
	logic               latched    = 1'b0;
	logic [COUNT_W-1:0] a_cnt      = '0;
	logic [COUNT_W-1:0] b_cnt      = '0;
	logic [STEP_W-1:0]  step_idx   = '0;
	logic [DUTY_W-1:0]  duty       = DUTY_W'(10000);

	result_t due_readings[$];
	int      errs  = 0;
	int      taken = 0;

	function automatic logic [DUTY_W-1:0] scaled_duty(input logic [STEP_W-1:0] st);
		int p;
		p = int'(st) * STEP_SIZE;
		return (p > 65535) ? {DUTY_W{1'b1}} : DUTY_W'(p);
	endfunction

	function automatic result_t advance_dimmer(input logic btn, input logic a_idle,
		input logic b_idle);
		result_t     r;
		event_kind_t ev;
		int          s;
		ev = EV_NONE;
		if (!btn && a_cnt == 0 && b_cnt == 0) begin
			if (!latched) begin
				hold_cnt = hold_cnt + HOLD_W'(1);
				if (hold_cnt >= hold_ticks) begin
					latched = 1'b1;
					s = (int'(step_idx) / TENTH) * TENTH + TENTH;
					if (s > MAX_STEP)
						s = 0;
					step_idx = STEP_W'(s);
					duty = scaled_duty(step_idx);
					ev = EV_BUTTON;
				end
			end
		end else begin
			hold_cnt = '0;
			latched = 1'b0;
		end
		if (!a_idle && a_cnt < COUNT_MAX && b_cnt < COUNT_MAX && hold_cnt == 0)
			a_cnt = a_cnt + COUNT_W'(1);
		if (!b_idle && a_cnt < COUNT_MAX && b_cnt < COUNT_MAX && hold_cnt == 0)
			b_cnt = b_cnt + COUNT_W'(1);
		if (a_idle && b_idle) begin
			if (a_cnt > edge_min && b_cnt > edge_min) begin
				s = int'(duty) / STEP_SIZE;
				if (a_cnt > b_cnt) begin
					if (s < MAX_STEP)
						s = s + 1;
					ev = EV_STEP_UP;
				end else begin
					if (s > 0)
						s = s - 1;
					ev = EV_STEP_DOWN;
				end
				step_idx = STEP_W'(s);
				duty = scaled_duty(step_idx);
			end
			a_cnt = '0;
			b_cnt = '0;
		end
		r.duty_value = duty;
		r.step_value = step_idx;
		r.event_kind = ev;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		result_t got;
		if (!arst_n) begin
			hold_ticks = HOLD_TICKS_RESET;
			edge_min = EDGE_MIN_RESET;
			hold_cnt = '0;
			latched = 1'b0;
			a_cnt = '0;
			b_cnt = '0;
			step_idx = '0;
			duty = DUTY_W'(10000);
			due_readings.delete();
			errs = 0;
			taken = 0;
			mismatches <= 0;
			outstanding <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_HOLD_TICKS)
					hold_ticks = cfg_data;
				else
					edge_min = cfg_data[EDGE_W-1:0];
			end
			if (s_tvalid && s_tready)
				due_readings.push_back(advance_dimmer(s_tdata[0], s_tdata[1], s_tdata[2]));
			if (m_tvalid && m_tready) begin
				got.duty_value = m_tdata[15:0];
				got.step_value = m_tdata[26:16];
				got.event_kind = event_kind_t'(m_tuser);
				if (due_readings.size() == 0) begin
					errs++;
					if (errs <= 10)
						$display("result %0d arrived with nothing expected:", taken,
							" duty %0d step %0d event %0d",
							got.duty_value, got.step_value, got.event_kind);
				end else begin
					want = due_readings.pop_front();
					if (got.duty_value !== want.duty_value || got.step_value !== want.step_value ||
						got.event_kind !== want.event_kind) begin
						errs++;
						if (errs <= 10)
							$display("result %0d mismatch:", taken,
								" expected duty %0d step %0d event %0d,",
								want.duty_value, want.step_value, want.event_kind,
								" got duty %0d step %0d event %0d",
								got.duty_value, got.step_value, got.event_kind);
					end
				end
				taken++;
			end
			mismatches <= errs;
			outstanding <= due_readings.size();
		end
	end

endmodule

// ===== bench/tb_encoder_button_duty_stepper.sv =====
// Testbench top that drives button and encoder ticks and register writes into the duty stepper.
`timescale 1ns / 1ps

module tb_encoder_button_duty_stepper;
	import ebds_pkg::*;

	localparam int QUIET_LIMIT = 1000;

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   s_tvalid  = 1'b0;
	logic                   s_tready;
	logic [7:0]             s_tdata   = 8'h07;
	logic                   m_tvalid;
	logic                   m_tready  = 1'b0;
	logic [31:0]            m_tdata;
	logic [EVENT_W-1:0]     m_tuser;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = CFG_HOLD_TICKS;
	logic [CFG_DATA_W-1:0]  cfg_data  = '0;

	int mismatches;
	int outstanding;
	int quiet      = 0;
	int ticks_sent = 0;
	int hold_now   = 500;
	int edge_now   = 5;
	bit steady     = 1'b0;

	encoder_button_duty_stepper dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	ebds_checker chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
			quiet <= 0;
		end else if (quiet >= QUIET_LIMIT) begin
			$display("tb_encoder_button_duty_stepper: FAIL");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	initial begin
		int stall;
		wait (arst_n);
		forever begin
			stall = steady ? 0 : $urandom_range(0, 4);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
		end
	end

	task automatic send_tick(input logic btn, input logic a, input logic b);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {5'b0, b, a, btn};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		ticks_sent++;
	endtask

	// The first edge lets the count of pending results take in the last transfer.
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] val);
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == CFG_HOLD_TICKS)
			hold_now = int'(val);
		else
			edge_now = int'(val[EDGE_W-1:0]);
	endtask

	function automatic logic idle_level(input bit noisy, input int odds);
		return (noisy && $urandom_range(0, odds) == 0) ? 1'b0 : 1'b1;
	endfunction

	function automatic int pick_len(input int kmax);
		return ($urandom_range(0, 63) == 0) ? $urandom_range(200, 280) : $urandom_range(0, kmax);
	endfunction

	// One detent: A leads for k1 ticks, both are low for k2, B trails for k3, then both idle.
	task automatic turn(input int k1, input int k2, input int k3, input bit noisy);
		for (int i = 0; i < k1; i++) send_tick(idle_level(noisy, 3), 1'b0, 1'b1);
		for (int i = 0; i < k2; i++) send_tick(idle_level(noisy, 3), 1'b0, 1'b0);
		for (int i = 0; i < k3; i++) send_tick(idle_level(noisy, 3), 1'b1, 1'b0);
		send_tick(1'b1, 1'b1, 1'b1);
	endtask

	task automatic press(input bit noisy);
		int need;
		int n;
		need = (hold_now == 0) ? 1 : hold_now;
		if (need > 300)
			n = $urandom_range(20, 300);
		else if ($urandom_range(0, 3) == 0)
			n = need - 1;
		else
			n = need + $urandom_range(0, 3);
		for (int i = 0; i < n; i++) send_tick(1'b0, idle_level(noisy, 7), idle_level(noisy, 7));
		repeat ($urandom_range(1, 2)) send_tick(1'b1, 1'b1, 1'b1);
	endtask

	task automatic run_mix(input int quota);
		int start;
		int kind;
		int kmax;
		int lead;
		int trail;
		start = ticks_sent;
		while (ticks_sent - start < quota) begin
			steady = ($urandom_range(0, 3) == 0);
			kind = $urandom_range(0, 9);
			if (kind < 4) begin
				kmax = (edge_now > 20) ? 8 : edge_now + 3;
				lead = pick_len(kmax);
				trail = pick_len(kmax);
				turn(lead, pick_len(kmax), trail, $urandom_range(0, 7) == 0);
			end else if (kind < 7) begin
				press($urandom_range(0, 3) == 0);
			end else begin
				repeat ($urandom_range(1, 6))
					send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
						1'($urandom_range(0, 1)));
			end
			if ($urandom_range(0, 19) == 0)
				drain();
		end
		steady = 1'b0;
	endtask

	initial begin
		int hold_set[8];
		int edge_set[8];
		hold_set = '{1, 0, 3, 65535, 7, 2, 12, 1};
		edge_set = '{0, 5, 2, 254, 255, 1, 10, 3};
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: the first detent recomputes the step from the reset duty.
		send_tick(1'b1, 1'b1, 1'b1);
		turn(1, 4, 1, 1'b0);
		turn(2, 4, 2, 1'b0);
		turn(3, 4, 2, 1'b0);
		send_tick(1'b0, 1'b1, 1'b1);
		send_tick(1'b1, 1'b1, 1'b1);
		steady = 1'b1;
		repeat (505) send_tick(1'b0, 1'b1, 1'b1);
		steady = 1'b0;
		send_tick(1'b1, 1'b1, 1'b1);

		for (int p = 0; p < 8; p++) begin
			write_reg(CFG_HOLD_TICKS, CFG_DATA_W'(hold_set[p]));
			if (edge_set[p] == 255)
				write_reg(CFG_EDGE_MIN, {8'hA5, 8'hFF});
			else
				write_reg(CFG_EDGE_MIN, CFG_DATA_W'(edge_set[p]));
			if (p == 0) begin
				// Climb to full scale, clamp a turn up, wrap past the top, clamp a turn down.
				repeat (8) begin
					send_tick(1'b0, 1'b1, 1'b1);
					send_tick(1'b1, 1'b1, 1'b1);
				end
				turn(2, 1, 1, 1'b0);
				send_tick(1'b0, 1'b1, 1'b1);
				send_tick(1'b1, 1'b1, 1'b1);
				turn(1, 1, 2, 1'b0);
			end
			run_mix(150);
		end

		drain();
		repeat (10) @(posedge clk);
		if (mismatches == 0) begin
			$display("tb_encoder_button_duty_stepper: PASS");
		end else begin
			$display("tb_encoder_button_duty_stepper: FAIL");
		end
		$finish;
	end

endmodule

// ===== encoder_button_duty_stepper.f =====
rtl/ebds_pkg.sv
rtl/encoder_button_duty_stepper.sv
bench/ebds_checker.sv
bench/tb_encoder_button_duty_stepper.sv
